/* hw/rtl/qrs_pkg.sv */
// ============================================================================
// qrs_pkg
// Shared types for the quadratic root solver: the result case codes.
// ============================================================================
`default_nettype none

package qrs_pkg;

    typedef enum logic [2:0] {
        CASE_NONE    = 3'd0,
        CASE_INF     = 3'd1,
        CASE_LINEAR  = 3'd2,
        CASE_DOUBLE  = 3'd3,
        CASE_TWO     = 3'd4,
        CASE_COMPLEX = 3'd5
    } t_root_case;

endpackage

`default_nettype wire

/* hw/rtl/qrs_div.sv */
// ============================================================================
// qrs_div
// Pipelined restoring divider, one quotient bit per stage. Computes
// (num * 2^FRAC_BITS) / den for unsigned operands, truncated.
// ============================================================================
`default_nettype none

module qrs_div #(
    parameter int NUM_BITS  = 34,
    parameter int DEN_BITS  = 33,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [NUM_BITS-1:0]           i_num,
    input  wire logic [DEN_BITS-1:0]           i_den,
    output logic      [NUM_BITS+FRAC_BITS-1:0] o_quo
);

    localparam int QB = NUM_BITS + FRAC_BITS;

    logic [DEN_BITS-1:0] r_rem [QB];
    logic [DEN_BITS-1:0] r_den [QB];
    logic [QB-1:0]       r_num [QB];
    logic [QB-1:0]       r_quo [QB];
    logic [DEN_BITS-1:0] n_rem [QB];
    logic [DEN_BITS-1:0] n_den [QB];
    logic [QB-1:0]       n_num [QB];
    logic [QB-1:0]       n_quo [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [DEN_BITS-1:0] p_rem;
        logic [DEN_BITS-1:0] p_den;
        logic [QB-1:0]       p_num;
        logic [QB-1:0]       p_quo;
        logic [DEN_BITS:0]   t;
        logic                ge;

        if (k == 0) begin : g_first
            assign p_rem = '0;
            assign p_den = i_den;
            assign p_num = {i_num, {FRAC_BITS{1'b0}}};
            assign p_quo = '0;
        end else begin : g_next
            assign p_rem = r_rem[k-1];
            assign p_den = r_den[k-1];
            assign p_num = r_num[k-1];
            assign p_quo = r_quo[k-1];
        end

        assign t        = {p_rem, p_num[QB-1]};
        assign ge       = (t >= {1'b0, p_den});
        assign n_rem[k] = ge ? DEN_BITS'(t - {1'b0, p_den}) : t[DEN_BITS-1:0];
        assign n_den[k] = p_den;
        assign n_num[k] = {p_num[QB-2:0], 1'b0};
        assign n_quo[k] = {p_quo[QB-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QB; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= n_den[k];
                r_num[k] <= n_num[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_quo = r_quo[QB-1];

endmodule

`default_nettype wire

/* hw/rtl/quadratic_root_solver_top.sv */
// Throughput: one request per cycle while the output is not stalled; the square root and both
// dividers are fully pipelined, one result bit per stage, and the whole pipeline advances together.
// Backpressure on the output stalls every stage at once; nothing is lost or repeated.
// Reset clears the stage valid bits only; data registers are not reset.
// ============================================================================
// quadratic_root_solver_top
// Real roots of a*x^2 + b*x + c = 0 in signed fixed point, with case code,
// exact discriminant, floored square root and saturating truncated division.
// ============================================================================
`default_nettype none

module quadratic_root_solver_top #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic signed [WORD_BITS-1:0] i_coef_a,
    input  wire logic signed [WORD_BITS-1:0] i_coef_b,
    input  wire logic signed [WORD_BITS-1:0] i_coef_c,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic             [2:0]           o_root_case,
    output logic signed      [WORD_BITS-1:0] o_root_low,
    output logic signed      [WORD_BITS-1:0] o_root_high,
    output logic                             o_overflow
);

    localparam int W   = WORD_BITS;
    localparam int SB  = W + 1;
    localparam int DW  = 2 * SB;
    localparam int RW  = SB + 2;
    localparam int NW  = W + 2;
    localparam int DNW = W + 1;
    localparam int QB  = NW + FRAC_BITS;
    localparam int LAT = 2 * W + FRAC_BITS + 8;

    logic en;
    logic [LAT-1:0] r_vld;

    assign en          = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    logic [W-1:0] r_a_a, r_a_b, r_a_c;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_a <= i_coef_a;
            r_a_b <= i_coef_b;
            r_a_c <= i_coef_c;
        end
    end

    logic [W-1:0]   mag_a, mag_b, mag_c;
    logic [2*W-1:0] r_b_bb, r_b_ac;
    logic [W-1:0]   r_b_a, r_b_b, r_b_c;
    logic           r_b_qneg;

    assign mag_a = r_a_a[W-1] ? (~r_a_a + 1'b1) : r_a_a;
    assign mag_b = r_a_b[W-1] ? (~r_a_b + 1'b1) : r_a_b;
    assign mag_c = r_a_c[W-1] ? (~r_a_c + 1'b1) : r_a_c;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_bb   <= mag_b * mag_b;
            r_b_ac   <= mag_a * mag_c;
            r_b_a    <= r_a_a;
            r_b_b    <= r_a_b;
            r_b_c    <= r_a_c;
            r_b_qneg <= (r_a_a[W-1] != r_a_c[W-1]) && (r_a_c != '0);
        end
    end

    logic [DW-1:0] disc_p, disc_q, disc_sum, disc_diff;
    logic          disc_gt, disc_eq;
    qrs_pkg::t_root_case n_c_kase;
    qrs_pkg::t_root_case r_c_kase;
    logic [DW-1:0] r_c_d;
    logic [W-1:0]  r_c_a, r_c_b, r_c_c;

    assign disc_p    = {2'b00, r_b_bb};
    assign disc_q    = {r_b_ac, 2'b00};
    assign disc_sum  = disc_p + disc_q;
    assign disc_diff = disc_p - disc_q;
    assign disc_gt   = disc_p > disc_q;
    assign disc_eq   = disc_p == disc_q;

    always_comb begin
        if (r_b_a == '0) begin
            if (r_b_b == '0) begin
                n_c_kase = (r_b_c == '0) ? qrs_pkg::CASE_INF : qrs_pkg::CASE_NONE;
            end else begin
                n_c_kase = qrs_pkg::CASE_LINEAR;
            end
        end else if (r_b_qneg || disc_gt) begin
            n_c_kase = qrs_pkg::CASE_TWO;
        end else if (disc_eq) begin
            n_c_kase = qrs_pkg::CASE_DOUBLE;
        end else begin
            n_c_kase = qrs_pkg::CASE_COMPLEX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_kase <= n_c_kase;
            r_c_d    <= r_b_qneg ? disc_sum : (disc_gt ? disc_diff : '0);
            r_c_a    <= r_b_a;
            r_c_b    <= r_b_b;
            r_c_c    <= r_b_c;
        end
    end

    logic [RW-1:0] r_sq_rem  [SB];
    logic [SB-1:0] r_sq_root [SB];
    logic [DW-1:0] r_sq_d    [SB];
    logic [RW-1:0] n_sq_rem  [SB];
    logic [SB-1:0] n_sq_root [SB];
    logic [DW-1:0] n_sq_d    [SB];
    qrs_pkg::t_root_case r_sq_kase [SB];
    logic [W-1:0]  r_sq_a [SB];
    logic [W-1:0]  r_sq_b [SB];
    logic [W-1:0]  r_sq_c [SB];

    for (genvar k = 0; k < SB; k++) begin : g_sqrt
        logic [RW-1:0] p_rem;
        logic [SB-1:0] p_root;
        logic [DW-1:0] p_d;
        logic [RW+1:0] t;
        logic [RW+1:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_d    = r_c_d;
        end else begin : g_next
            assign p_rem  = r_sq_rem[k-1];
            assign p_root = r_sq_root[k-1];
            assign p_d    = r_sq_d[k-1];
        end

        assign t            = {p_rem, p_d[DW-1:DW-2]};
        assign trial        = {2'b00, p_root, 2'b01};
        assign ge           = t >= trial;
        assign n_sq_rem[k]  = ge ? RW'(t - trial) : t[RW-1:0];
        assign n_sq_root[k] = {p_root[SB-2:0], ge};
        assign n_sq_d[k]    = {p_d[DW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < SB; k++) begin
                r_sq_rem[k]  <= n_sq_rem[k];
                r_sq_root[k] <= n_sq_root[k];
                r_sq_d[k]    <= n_sq_d[k];
            end
            r_sq_kase[0] <= r_c_kase;
            r_sq_a[0]    <= r_c_a;
            r_sq_b[0]    <= r_c_b;
            r_sq_c[0]    <= r_c_c;
            for (int k = 1; k < SB; k++) begin
                r_sq_kase[k] <= r_sq_kase[k-1];
                r_sq_a[k]    <= r_sq_a[k-1];
                r_sq_b[k]    <= r_sq_b[k-1];
                r_sq_c[k]    <= r_sq_c[k-1];
            end
        end
    end

    qrs_pkg::t_root_case nk;
    logic [NW-1:0]  nb_x, nc_x, s_x, lo_s, hi_s;
    logic [DNW-1:0] den_s;
    logic [NW-1:0]  r_n_lo_mag, r_n_hi_mag;
    logic [DNW-1:0] r_n_den_mag;
    logic           r_n_lo_neg, r_n_hi_neg;
    qrs_pkg::t_root_case r_n_kase;

    assign nk   = r_sq_kase[SB-1];
    assign nb_x = NW'(0) - {{2{r_sq_b[SB-1][W-1]}}, r_sq_b[SB-1]};
    assign nc_x = NW'(0) - {{2{r_sq_c[SB-1][W-1]}}, r_sq_c[SB-1]};
    assign s_x  = {1'b0, r_sq_root[SB-1]};
    assign hi_s = nb_x + s_x;

    always_comb begin
        case (nk)
            qrs_pkg::CASE_LINEAR: lo_s = nc_x;
            qrs_pkg::CASE_TWO:    lo_s = nb_x - s_x;
            default:              lo_s = nb_x;
        endcase
        if (nk == qrs_pkg::CASE_LINEAR) begin
            den_s = {r_sq_b[SB-1][W-1], r_sq_b[SB-1]};
        end else begin
            den_s = {r_sq_a[SB-1], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_lo_mag  <= lo_s[NW-1] ? (~lo_s + 1'b1) : lo_s;
            r_n_hi_mag  <= hi_s[NW-1] ? (~hi_s + 1'b1) : hi_s;
            r_n_den_mag <= den_s[DNW-1] ? (~den_s + 1'b1) : den_s;
            r_n_lo_neg  <= lo_s[NW-1] != den_s[DNW-1];
            r_n_hi_neg  <= hi_s[NW-1] != den_s[DNW-1];
            r_n_kase    <= nk;
        end
    end

    logic [QB-1:0] quo_lo, quo_hi;

    qrs_div #(
        .NUM_BITS (NW),
        .DEN_BITS (DNW),
        .FRAC_BITS(FRAC_BITS)
    ) u_div_lo (
        .i_clk(i_clk),
        .i_en (en),
        .i_num(r_n_lo_mag),
        .i_den(r_n_den_mag),
        .o_quo(quo_lo)
    );

    qrs_div #(
        .NUM_BITS (NW),
        .DEN_BITS (DNW),
        .FRAC_BITS(FRAC_BITS)
    ) u_div_hi (
        .i_clk(i_clk),
        .i_en (en),
        .i_num(r_n_hi_mag),
        .i_den(r_n_den_mag),
        .o_quo(quo_hi)
    );

    qrs_pkg::t_root_case r_dv_kase [QB];
    logic r_dv_lo_neg [QB];
    logic r_dv_hi_neg [QB];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_kase[0]   <= r_n_kase;
            r_dv_lo_neg[0] <= r_n_lo_neg;
            r_dv_hi_neg[0] <= r_n_hi_neg;
            for (int k = 1; k < QB; k++) begin
                r_dv_kase[k]   <= r_dv_kase[k-1];
                r_dv_lo_neg[k] <= r_dv_lo_neg[k-1];
                r_dv_hi_neg[k] <= r_dv_hi_neg[k-1];
            end
        end
    end

    localparam logic [QB-1:0] LIM_Q   = QB'(1) << (W - 1);
    localparam logic [W-1:0]  MIN_W   = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0]  MAX_W   = {1'b0, {(W-1){1'b1}}};

    qrs_pkg::t_root_case ok;
    logic         lo_neg, hi_neg, ovf_lo, ovf_hi;
    logic [W-1:0] sat_lo, sat_hi;
    logic [2:0]   r_o_case;
    logic [W-1:0] r_o_low, r_o_high;
    logic         r_o_ovf;

    assign ok     = r_dv_kase[QB-1];
    assign lo_neg = r_dv_lo_neg[QB-1];
    assign hi_neg = r_dv_hi_neg[QB-1];
    assign ovf_lo = lo_neg ? (quo_lo > LIM_Q) : (quo_lo > LIM_Q - 1'b1);
    assign ovf_hi = hi_neg ? (quo_hi > LIM_Q) : (quo_hi > LIM_Q - 1'b1);

    always_comb begin
        if (lo_neg) begin
            sat_lo = ovf_lo ? MIN_W : (~quo_lo[W-1:0] + 1'b1);
        end else begin
            sat_lo = ovf_lo ? MAX_W : quo_lo[W-1:0];
        end
        if (hi_neg) begin
            sat_hi = ovf_hi ? MIN_W : (~quo_hi[W-1:0] + 1'b1);
        end else begin
            sat_hi = ovf_hi ? MAX_W : quo_hi[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_case <= ok;
            case (ok)
                qrs_pkg::CASE_LINEAR, qrs_pkg::CASE_DOUBLE: begin
                    r_o_low  <= sat_lo;
                    r_o_high <= '0;
                    r_o_ovf  <= ovf_lo;
                end
                qrs_pkg::CASE_TWO: begin
                    r_o_low  <= sat_lo;
                    r_o_high <= sat_hi;
                    r_o_ovf  <= ovf_lo || ovf_hi;
                end
                default: begin
                    r_o_low  <= '0;
                    r_o_high <= '0;
                    r_o_ovf  <= 1'b0;
                end
            endcase
        end
    end

    assign o_root_case = r_o_case;
    assign o_root_low  = r_o_low;
    assign o_root_high = r_o_high;
    assign o_overflow  = r_o_ovf;

    a_no_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_root_case == qrs_pkg::CASE_NONE || o_root_case == qrs_pkg::CASE_INF
            || o_root_case == qrs_pkg::CASE_COMPLEX)
        |-> o_root_low == '0 && o_root_high == '0 && !o_overflow)
        else $error("root fields not cleared for a case without roots");

    a_single_root_high_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_root_case == qrs_pkg::CASE_LINEAR
            || o_root_case == qrs_pkg::CASE_DOUBLE)
        |-> o_root_high == '0)
        else $error("second root not cleared for a single-root case");

    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

endmodule

`default_nettype wire
